FILE: sv/ims_pkg.sv
// shared constants, types and command structs of the ising spin update block
package ims_pkg;

    localparam int LatticeWidth = 64;
    localparam int LatticeHeight = 64;
    localparam int SiteCount = LatticeWidth * LatticeHeight;

    localparam int SiteW = 12;
    localparam int XW = $clog2(LatticeWidth);
    localparam int RowAW = $clog2(LatticeHeight);
    localparam int YW = SiteW;

    // row = site / width as a multiply by a rounded-up reciprocal, exact for all 12-bit sites
    localparam int DivShift = SiteW + XW;
    localparam int DivMul = ((1 << DivShift) + LatticeWidth - 1) / LatticeWidth;
    localparam int DivMulW = $clog2(DivMul + 1);
    localparam int DivProdW = SiteW + DivMulW;

    localparam int ActionW = 2;
    localparam int RndW = 16;
    localparam int ThrW = 17;
    localparam int ProdW = 4;
    localparam int MagW = 14;
    localparam int BondW = 15;
    localparam int EqW = 3;

    localparam int NumThr = 5;
    localparam int CfgAW = 5;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;

    localparam logic [ActionW-1:0] ActLoad = 2'd0;
    localparam logic [ActionW-1:0] ActTrial = 2'd1;

    typedef logic [ThrW-1:0] thr_t;
    typedef thr_t [NumThr-1:0] thr_array_t;

    // index 0 is spin times neighbor sum of -4, index 4 is +4
    localparam thr_array_t ThrReset = {17'd0, 17'd0, 17'd65536, 17'd65536, 17'd65536};

    localparam logic [MagW-1:0] MagReset = MagW'(SiteCount);
    localparam logic [BondW-1:0] BondReset = BondW'(2 * SiteCount);

    typedef struct packed {
        logic accept;
        logic rd_mid;
        logic rd_up;
        logic rd_dn;
        logic eval;
        logic clear_wr;
    } ims_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ims_status_t;

endpackage

FILE: sv/ising_metropolis_spin_update.sv
// top level of the ising lattice metropolis spin update block
// Each request (load, Metropolis trial or read of one site) steps through the states
// MID, UP, DN and EVAL from acceptance to a result in the output register, and no new
// request is taken before the last one is through: the lattice memory holds one
// row per address behind a single read port, so the site's row, the row above and
// the row below are read one after another before the evaluate-and-write-back cycle.
// One request is in work at a time; the next is taken as soon as the result is
// registered, even while that result still waits on m_tready. After reset a clearing
// pass writes every row to spin +1, one row per cycle; s_tready stays low until it
// ends, while threshold writes are taken as ever.
module ising_metropolis_spin_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // site[11:0], spin_value[12], random_fraction[28:13]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // spin_now[0], flipped[1], local_product[5:2],
                                   // magnetization[19:6], bond_total[34:20]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ims_pkg::ims_cmd_t                  cmd;
    ims_pkg::ims_status_t               status;
    ims_pkg::thr_array_t                thr;
    logic                               spin_now;
    logic                               flipped;
    logic signed [ims_pkg::ProdW-1:0]   local_product;
    logic signed [ims_pkg::MagW-1:0]    magnetization;
    logic signed [ims_pkg::BondW-1:0]   bond_total;

    assign pready = 1'b1;

    ims_regs u_regs (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .thr(thr)
    );

    ims_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status(status),
        .cmd(cmd)
    );

    ims_datapath u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .thr(thr),
        .in_action(s_tuser),
        .in_site(s_tdata[11:0]),
        .in_spin(s_tdata[12]),
        .in_rnd(s_tdata[28:13]),
        .spin_now(spin_now),
        .flipped(flipped),
        .local_product(local_product),
        .magnetization(magnetization),
        .bond_total(bond_total)
    );

    assign m_tdata = {5'd0, bond_total, magnetization, local_product, flipped, spin_now};

    // busy after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a previous one is in work");

    // every flip moves magnetization by two, so its parity never changes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6] == ims_pkg::MagReset[0])
        else $error("magnetization parity lost");

    // every flip moves the bond sum by a multiple of four
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[21:20] == ims_pkg::BondReset[1:0])
        else $error("bond sum off its lattice of values");

    // a waiting result holds still until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while waiting");

endmodule

FILE: sv/ims_ram.sv
// generic single-port-write ram with registered read
module ims_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
    input  logic [Width-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
    output logic [Width-1:0]                       rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ims_regs.sv
// apb threshold registers
module ims_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ims_pkg::CfgAW-1:0]       paddr,
    input  logic [ims_pkg::CfgDataW-1:0]    pwdata,
    output logic [ims_pkg::CfgDataW-1:0]    prdata,
    output ims_pkg::thr_array_t             thr
);

    ims_pkg::thr_array_t               thr_reg;
    logic                              wr_en;
    logic [ims_pkg::CfgIdxW-1:0]       reg_idx;
    logic [ims_pkg::CfgDataW-1:0]      rd_data;

    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[ims_pkg::CfgAW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= ims_pkg::ThrReset;
        end
        else if (wr_en)
        begin
            for (int i = 0; i < ims_pkg::NumThr; i++)
            begin
                if (reg_idx == ims_pkg::CfgIdxW'(i))
                begin
                    thr_reg[i] <= pwdata[ims_pkg::ThrW-1:0];
                end
            end
        end
    end

    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < ims_pkg::NumThr; i++)
        begin
            if (reg_idx == ims_pkg::CfgIdxW'(i))
            begin
                rd_data = ims_pkg::CfgDataW'(thr_reg[i]);
            end
        end
    end

    assign prdata = rd_data;
    assign thr = thr_reg;

endmodule

FILE: sv/ims_ctrl.sv
// sequencing state machine for clearing, row reads and evaluation
module ims_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ims_pkg::ims_status_t status,
    output ims_pkg::ims_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MID,
        ST_UP,
        ST_DN,
        ST_EVAL
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd = '0;
        cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
        cmd.rd_mid = (state_reg == ST_MID);
        cmd.rd_up = (state_reg == ST_UP);
        cmd.rd_dn = (state_reg == ST_DN);
        cmd.eval = (state_reg == ST_EVAL) && out_free;
        cmd.clear_wr = (state_reg == ST_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_EVAL) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (status.clear_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_MID;
                    end
                end
                ST_MID:
                begin
                    state_reg <= ST_UP;
                end
                ST_UP:
                begin
                    state_reg <= ST_DN;
                end
                ST_DN:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

FILE: sv/ims_datapath.sv
// lattice memory, site decode, neighbor evaluation and running sums
module ims_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ims_pkg::ims_cmd_t                   cmd,
    output ims_pkg::ims_status_t                status,
    input  ims_pkg::thr_array_t                 thr,
    input  logic [ims_pkg::ActionW-1:0]         in_action,
    input  logic [ims_pkg::SiteW-1:0]           in_site,
    input  logic                                in_spin,
    input  logic [ims_pkg::RndW-1:0]            in_rnd,
    output logic                                spin_now,
    output logic                                flipped,
    output logic signed [ims_pkg::ProdW-1:0]    local_product,
    output logic signed [ims_pkg::MagW-1:0]     magnetization,
    output logic signed [ims_pkg::BondW-1:0]    bond_total
);

    logic [ims_pkg::ActionW-1:0]          action_reg;
    logic [ims_pkg::SiteW-1:0]            site_reg;
    logic                                 spin_val_reg;
    logic [ims_pkg::RndW-1:0]             rnd_reg;
    logic                                 in_range_reg;
    logic [ims_pkg::YW-1:0]               y_reg;
    logic [ims_pkg::XW-1:0]               x_reg;
    logic [ims_pkg::LatticeWidth-1:0]     mid_row_reg;
    logic                                 up_bit_reg;
    logic [ims_pkg::RowAW-1:0]            clear_row_reg;
    logic signed [ims_pkg::MagW-1:0]      mag_reg;
    logic signed [ims_pkg::MagW-1:0]      mag_next;
    logic signed [ims_pkg::BondW-1:0]     bond_reg;
    logic signed [ims_pkg::BondW-1:0]     bond_next;
    logic                                 spin_now_reg;
    logic                                 flipped_reg;
    logic signed [ims_pkg::ProdW-1:0]     prod_reg;

    logic [ims_pkg::DivProdW-1:0]         div_prod;
    logic [ims_pkg::RowAW-1:0]            y_row;
    logic [ims_pkg::RowAW-1:0]            yu_row;
    logic [ims_pkg::RowAW-1:0]            yd_row;
    logic [ims_pkg::XW-1:0]               xl;
    logic [ims_pkg::XW-1:0]               xr;

    logic                                 ram_we;
    logic [ims_pkg::RowAW-1:0]            ram_waddr;
    logic [ims_pkg::LatticeWidth-1:0]     ram_wdata;
    logic                                 ram_re;
    logic [ims_pkg::RowAW-1:0]            ram_raddr;
    logic [ims_pkg::LatticeWidth-1:0]     ram_rdata;

    logic                                 s_bit;
    logic                                 dn_bit;
    logic [ims_pkg::EqW-1:0]              eq_count;
    logic signed [ims_pkg::ProdW-1:0]     prod_val;
    ims_pkg::thr_t                        thr_sel;
    logic                                 flip;
    logic                                 new_bit;
    logic [ims_pkg::LatticeWidth-1:0]     new_row;

    assign div_prod = ims_pkg::DivProdW'(in_site) * ims_pkg::DivProdW'(ims_pkg::DivMul);

    assign y_row = y_reg[ims_pkg::RowAW-1:0];
    assign yu_row = (y_row == '0) ? ims_pkg::RowAW'(ims_pkg::LatticeHeight - 1) : y_row - 1'b1;
    assign yd_row = (y_row == ims_pkg::RowAW'(ims_pkg::LatticeHeight - 1)) ? '0 : y_row + 1'b1;
    assign xl = (x_reg == '0) ? ims_pkg::XW'(ims_pkg::LatticeWidth - 1) : x_reg - 1'b1;
    assign xr = (x_reg == ims_pkg::XW'(ims_pkg::LatticeWidth - 1)) ? '0 : x_reg + 1'b1;

    // neighbor evaluation
    assign s_bit = mid_row_reg[x_reg];
    assign dn_bit = ram_rdata[x_reg];

    always_comb
    begin
        eq_count = ims_pkg::EqW'(mid_row_reg[xl] == s_bit)
                 + ims_pkg::EqW'(mid_row_reg[xr] == s_bit)
                 + ims_pkg::EqW'(up_bit_reg == s_bit)
                 + ims_pkg::EqW'(dn_bit == s_bit);
        prod_val = $signed({eq_count, 1'b0} - ims_pkg::ProdW'(4));

        unique case (eq_count)
            3'd0: thr_sel = thr[0];
            3'd1: thr_sel = thr[1];
            3'd2: thr_sel = thr[2];
            3'd3: thr_sel = thr[3];
            default: thr_sel = thr[ims_pkg::NumThr-1];
        endcase

        unique case (action_reg)
            ims_pkg::ActLoad: flip = spin_val_reg ^ s_bit;
            ims_pkg::ActTrial: flip = ({1'b0, rnd_reg} < thr_sel);
            default: flip = 1'b0;
        endcase
        flip = flip && in_range_reg;
        new_bit = s_bit ^ flip;

        new_row = mid_row_reg;
        new_row[x_reg] = new_bit;

        mag_next = mag_reg;
        bond_next = bond_reg;
        if (flip)
        begin
            mag_next = s_bit ? mag_reg + ims_pkg::MagW'(2) : mag_reg - ims_pkg::MagW'(2);
            bond_next = bond_reg - (ims_pkg::BondW'(prod_val) <<< 1);
        end
    end

    // lattice memory, one row per address
    always_comb
    begin
        ram_re = cmd.rd_mid || cmd.rd_up || cmd.rd_dn;
        priority if (cmd.rd_mid)
        begin
            ram_raddr = y_row;
        end
        else if (cmd.rd_up)
        begin
            ram_raddr = yu_row;
        end
        else
        begin
            ram_raddr = yd_row;
        end
        ram_we = cmd.clear_wr || (cmd.eval && in_range_reg);
        ram_waddr = cmd.clear_wr ? clear_row_reg : y_row;
        ram_wdata = cmd.clear_wr ? '0 : new_row;
    end

    ims_ram #(
        .Width(ims_pkg::LatticeWidth),
        .Depth(ims_pkg::LatticeHeight)
    ) u_lattice (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_row_reg <= '0;
            mag_reg <= ims_pkg::MagReset;
            bond_reg <= ims_pkg::BondReset;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clear_row_reg <= clear_row_reg + 1'b1;
            end
            if (cmd.eval)
            begin
                mag_reg <= mag_next;
                bond_reg <= bond_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= in_action;
            site_reg <= in_site;
            spin_val_reg <= in_spin;
            rnd_reg <= in_rnd;
            in_range_reg <= (32'(in_site) < 32'(ims_pkg::SiteCount));
            y_reg <= ims_pkg::YW'(div_prod >> ims_pkg::DivShift);
        end
        if (cmd.rd_mid)
        begin
            x_reg <= ims_pkg::XW'(site_reg - ims_pkg::SiteW'(y_reg * ims_pkg::LatticeWidth));
        end
        if (cmd.rd_up)
        begin
            mid_row_reg <= ram_rdata;
        end
        if (cmd.rd_dn)
        begin
            up_bit_reg <= ram_rdata[x_reg];
        end
        if (cmd.eval)
        begin
            spin_now_reg <= in_range_reg && new_bit;
            flipped_reg <= flip;
            prod_reg <= in_range_reg ? prod_val : '0;
        end
    end

    assign status.clear_last = (clear_row_reg == ims_pkg::RowAW'(ims_pkg::LatticeHeight - 1));

    assign spin_now = spin_now_reg;
    assign flipped = flipped_reg;
    assign local_product = prod_reg;
    assign magnetization = mag_reg;
    assign bond_total = bond_reg;

endmodule
